// ===== rtl/sith_pkg.sv =====
// ----------------------------------------------------------------------------
// sith_pkg
// Shared types, constants and the FNV-1a step for the string intern table.
// ----------------------------------------------------------------------------
package sith_pkg;

  localparam int SLOT_COUNT_DEF  = 64;
  localparam int MAX_KEY_LEN_DEF = 32;

  // Ids are 6 bits wide; id 0 marks an empty slot.
  localparam int ID_W     = 6;
  localparam int ID_LIMIT = 64;
  localparam int LOAD_NUM = 7;
  localparam int LOAD_DEN = 10;

  localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;

  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_MOD,
    S_PROBE_RD,
    S_PROBE_CK,
    S_LEN_CK,
    S_CMP_RD,
    S_CMP_CK,
    S_CP_RD,
    S_CP_WR,
    S_DONE
  } state_t;

  // Write enables of the key store.
  typedef struct packed {
    logic buf_we;
    logic key_we;
    logic len_we;
  } kwe_t;

  // One FNV-1a step. The prime is 2^40 + 0x1b3, so the product is a sum of shifts.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// ===== rtl/sith_hash.sv =====
// ----------------------------------------------------------------------------
// sith_hash
// Running 64-bit FNV-1a hash register, with a left shift for slot reduction.
// ----------------------------------------------------------------------------
module sith_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_en,
  input  logic [7:0]  byte_in,
  input  logic        shift_en,
  input  logic        clear,
  output logic [63:0] hash
);

  logic [63:0] hash_r;
  logic [63:0] hash_nxt;

  always_comb begin
    hash_nxt = hash_r;
    if (clear) begin
      hash_nxt = sith_pkg::FNV_BASIS;
    end else if (byte_en) begin
      hash_nxt = sith_pkg::fnv_step(hash_r, byte_in);
    end else if (shift_en) begin
      hash_nxt = {hash_r[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= sith_pkg::FNV_BASIS;
    end else begin
      hash_r <= hash_nxt;
    end
  end

  assign hash = hash_r;

endmodule

// ===== rtl/sith_slot_mem.sv =====
// ----------------------------------------------------------------------------
// sith_slot_mem
// Slot table: one id per slot, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sith_slot_mem #(
  parameter int SLOT_COUNT = sith_pkg::SLOT_COUNT_DEF,
  parameter int SB         = $clog2(SLOT_COUNT)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [SB-1:0]             waddr,
  input  logic [sith_pkg::ID_W-1:0] wdata,
  input  logic [SB-1:0]             raddr,
  output logic [sith_pkg::ID_W-1:0] rdata
);

  logic [sith_pkg::ID_W-1:0] mem [SLOT_COUNT];
  logic [sith_pkg::ID_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sith_key_store.sv =====
// ----------------------------------------------------------------------------
// sith_key_store
// Key buffer for the incoming key, stored key bytes and stored key lengths.
// ----------------------------------------------------------------------------
module sith_key_store #(
  parameter int MAX_KEY_LEN = sith_pkg::MAX_KEY_LEN_DEF,
  parameter int IW          = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1,
  parameter int CW          = $clog2(MAX_KEY_LEN + 1)
) (
  input  logic                         clk,
  input  sith_pkg::kwe_t               we,
  input  logic [IW-1:0]                buf_waddr,
  input  logic [7:0]                   buf_wdata,
  input  logic [IW-1:0]                buf_raddr,
  output logic [7:0]                   buf_rdata,
  input  logic [sith_pkg::ID_W+IW-1:0] key_addr,
  input  logic [7:0]                   key_wdata,
  output logic [7:0]                   key_rdata,
  input  logic [sith_pkg::ID_W-1:0]    len_waddr,
  input  logic [CW-1:0]                len_wdata,
  input  logic [sith_pkg::ID_W-1:0]    len_raddr,
  output logic [CW-1:0]                len_rdata
);

  localparam int KDEPTH = sith_pkg::ID_LIMIT << IW;

  logic [7:0]    buf_mem [1 << IW];
  logic [7:0]    key_mem [KDEPTH];
  logic [CW-1:0] len_mem [sith_pkg::ID_LIMIT];
  logic [7:0]    buf_rdata_r;
  logic [7:0]    key_rdata_r;
  logic [CW-1:0] len_rdata_r;

  always_ff @(posedge clk) begin
    if (we.buf_we) begin
      buf_mem[buf_waddr] <= buf_wdata;
    end
    buf_rdata_r <= buf_mem[buf_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.key_we) begin
      key_mem[key_addr] <= key_wdata;
    end
    key_rdata_r <= key_mem[key_addr];
  end

  always_ff @(posedge clk) begin
    if (we.len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_rdata_r <= len_mem[len_raddr];
  end

  assign buf_rdata = buf_rdata_r;
  assign key_rdata = key_rdata_r;
  assign len_rdata = len_rdata_r;

endmodule

// ===== rtl/string_intern_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// string_intern_hash_table_top
// Interns byte-string keys in a fixed FNV-1a hashed, linearly probed table.
// ----------------------------------------------------------------------------
// Key bytes are taken one word per cycle while the block is idle. The word that
// carries tlast starts the lookup, and no word is taken until its result has
// been placed in the output register: a start state, a reduction of the hash
// by binary long division when SLOT_COUNT is not a power of two, then per
// probed slot a slot memory read, a check of the stored length and a read and
// compare of each key byte, an insert copying the key byte by byte from the
// buffer memory into the key memory, and a delivery state.
// After reset a clearing pass writes id 0 to every slot of the slot memory;
// no word is accepted during it.
module string_intern_hash_table_top #(
  parameter int SLOT_COUNT  = sith_pkg::SLOT_COUNT_DEF,
  parameter int MAX_KEY_LEN = sith_pkg::MAX_KEY_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] key_byte, [8] byte_present, zero padding
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [5:0] entry_id, [7:6] status
);

  localparam int SB       = $clog2(SLOT_COUNT);
  localparam int IW       = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int CW       = $clog2(MAX_KEY_LEN + 1);
  localparam int IDW      = sith_pkg::ID_W;
  localparam bit POW2     = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;
  localparam int LOAD_MAX = (SLOT_COUNT * sith_pkg::LOAD_NUM) / sith_pkg::LOAD_DEN - 2;

  sith_pkg::state_t state_r, state_nxt;
  logic [SB-1:0]  slot_r, slot_nxt;
  logic [SB:0]    probe_r, probe_nxt;
  logic [SB-1:0]  mod_r, mod_nxt;
  logic [5:0]     modcnt_r, modcnt_nxt;
  logic [CW-1:0]  i_r, i_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           flag_r, flag_nxt;
  logic [IDW-1:0] pool_r, pool_nxt;
  logic [IDW-1:0] cur_id_r, cur_id_nxt;
  logic [IDW-1:0] res_id_r, res_id_nxt;
  logic [1:0]     res_st_r, res_st_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [IDW-1:0] out_id_r, out_id_nxt;
  logic [1:0]     out_st_r, out_st_nxt;

  logic           in_acc;
  logic           present;
  logic [63:0]    hash;
  logic           hash_clear;
  logic           hash_shift;
  logic           slot_we;
  logic [IDW-1:0] slot_wdata;
  logic [SB-1:0]  slot_raddr;
  logic [IDW-1:0] slot_rdata;
  sith_pkg::kwe_t kwe;
  logic [7:0]     buf_rdata;
  logic [7:0]     key_rdata;
  logic [IDW-1:0] len_raddr;
  logic [CW-1:0]  len_rdata;
  logic [SB:0]    mod_t;
  logic [SB-1:0]  slot_inc;
  logic           probe_end;

  assign present   = in_tdata[8];
  assign in_tready = (state_r == sith_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // One bit of binary long division per cycle; the remainder stays below SLOT_COUNT.
  assign mod_t     = {mod_r, hash[63]};
  assign slot_inc  = (slot_r == SB'(SLOT_COUNT - 1)) ? '0 : slot_r + 1'b1;
  assign probe_end = (probe_r == (SB + 1)'(SLOT_COUNT - 1));

  sith_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_en  (in_acc && present),
    .byte_in  (in_tdata[7:0]),
    .shift_en (hash_shift),
    .clear    (hash_clear),
    .hash     (hash)
  );

  sith_slot_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .SB         (SB)
  ) u_slot_mem (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_r),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  sith_key_store #(
    .MAX_KEY_LEN (MAX_KEY_LEN),
    .IW          (IW),
    .CW          (CW)
  ) u_key_store (
    .clk       (clk),
    .we        (kwe),
    .buf_waddr (cnt_r[IW-1:0]),
    .buf_wdata (in_tdata[7:0]),
    .buf_raddr (i_r[IW-1:0]),
    .buf_rdata (buf_rdata),
    .key_addr  ({cur_id_r, i_r[IW-1:0]}),
    .key_wdata (buf_rdata),
    .key_rdata (key_rdata),
    .len_waddr (cur_id_nxt),
    .len_wdata (cnt_r),
    .len_raddr (len_raddr),
    .len_rdata (len_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    probe_nxt     = probe_r;
    mod_nxt       = mod_r;
    modcnt_nxt    = modcnt_r;
    i_nxt         = i_r;
    cnt_nxt       = cnt_r;
    flag_nxt      = flag_r;
    pool_nxt      = pool_r;
    cur_id_nxt    = cur_id_r;
    res_id_nxt    = res_id_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_id_nxt    = out_id_r;
    out_st_nxt    = out_st_r;
    hash_clear    = 1'b0;
    hash_shift    = 1'b0;
    slot_we       = 1'b0;
    slot_wdata    = '0;
    slot_raddr    = slot_r;
    len_raddr     = slot_rdata;
    kwe           = '0;

    unique case (state_r)
      sith_pkg::S_CLEAR: begin
        slot_we  = 1'b1;
        slot_nxt = slot_inc;
        if (slot_r == SB'(SLOT_COUNT - 1)) begin
          state_nxt = sith_pkg::S_IDLE;
        end
      end
      sith_pkg::S_IDLE: begin
        if (in_acc) begin
          if (present) begin
            if (cnt_r < CW'(MAX_KEY_LEN)) begin
              kwe.buf_we = 1'b1;
              cnt_nxt    = cnt_r + 1'b1;
            end else begin
              flag_nxt = 1'b1;
            end
          end
          if (in_tlast) begin
            state_nxt = sith_pkg::S_START;
          end
        end
      end
      sith_pkg::S_START: begin
        probe_nxt  = '0;
        mod_nxt    = '0;
        modcnt_nxt = '0;
        if (flag_r) begin
          res_id_nxt = '0;
          res_st_nxt = sith_pkg::ST_TOO_LONG;
          state_nxt  = sith_pkg::S_DONE;
        end else if (POW2) begin
          slot_nxt  = hash[SB-1:0];
          state_nxt = sith_pkg::S_PROBE_RD;
        end else begin
          state_nxt = sith_pkg::S_MOD;
        end
      end
      sith_pkg::S_MOD: begin
        hash_shift = 1'b1;
        mod_nxt    = (mod_t >= (SB + 1)'(SLOT_COUNT)) ? SB'(mod_t - (SB + 1)'(SLOT_COUNT))
                                                      : mod_t[SB-1:0];
        modcnt_nxt = modcnt_r + 1'b1;
        if (modcnt_r == 6'd63) begin
          slot_nxt  = mod_nxt;
          state_nxt = sith_pkg::S_PROBE_RD;
        end
      end
      sith_pkg::S_PROBE_RD: begin
        state_nxt = sith_pkg::S_PROBE_CK;
      end
      sith_pkg::S_PROBE_CK: begin
        if (slot_rdata == '0) begin
          if ((int'(pool_r) > LOAD_MAX) || (pool_r == IDW'(sith_pkg::ID_LIMIT - 1))) begin
            res_id_nxt = '0;
            res_st_nxt = sith_pkg::ST_FULL;
            state_nxt  = sith_pkg::S_DONE;
          end else begin
            // Insert: the new id also addresses the length write this cycle.
            cur_id_nxt  = pool_r + 1'b1;
            pool_nxt    = cur_id_nxt;
            slot_we     = 1'b1;
            slot_wdata  = cur_id_nxt;
            kwe.len_we  = 1'b1;
            res_id_nxt  = cur_id_nxt;
            res_st_nxt  = sith_pkg::ST_INSERTED;
            i_nxt       = '0;
            state_nxt   = (cnt_r == '0) ? sith_pkg::S_DONE : sith_pkg::S_CP_RD;
          end
        end else begin
          cur_id_nxt = slot_rdata;
          state_nxt  = sith_pkg::S_LEN_CK;
        end
      end
      sith_pkg::S_LEN_CK: begin
        i_nxt = '0;
        if (len_rdata != cnt_r) begin
          slot_nxt  = slot_inc;
          probe_nxt = probe_r + 1'b1;
          state_nxt = probe_end ? sith_pkg::S_DONE : sith_pkg::S_PROBE_RD;
          res_id_nxt = '0;
          res_st_nxt = sith_pkg::ST_FULL;
        end else if (cnt_r == '0) begin
          res_id_nxt = cur_id_r;
          res_st_nxt = sith_pkg::ST_HIT;
          state_nxt  = sith_pkg::S_DONE;
        end else begin
          state_nxt = sith_pkg::S_CMP_RD;
        end
      end
      sith_pkg::S_CMP_RD: begin
        state_nxt = sith_pkg::S_CMP_CK;
      end
      sith_pkg::S_CMP_CK: begin
        if (key_rdata != buf_rdata) begin
          slot_nxt   = slot_inc;
          probe_nxt  = probe_r + 1'b1;
          state_nxt  = probe_end ? sith_pkg::S_DONE : sith_pkg::S_PROBE_RD;
          res_id_nxt = '0;
          res_st_nxt = sith_pkg::ST_FULL;
        end else if (i_r + 1'b1 == cnt_r) begin
          res_id_nxt = cur_id_r;
          res_st_nxt = sith_pkg::ST_HIT;
          state_nxt  = sith_pkg::S_DONE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = sith_pkg::S_CMP_RD;
        end
      end
      sith_pkg::S_CP_RD: begin
        state_nxt = sith_pkg::S_CP_WR;
      end
      sith_pkg::S_CP_WR: begin
        kwe.key_we = 1'b1;
        i_nxt      = i_r + 1'b1;
        state_nxt  = (i_r + 1'b1 == cnt_r) ? sith_pkg::S_DONE : sith_pkg::S_CP_RD;
      end
      sith_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = res_id_r;
          out_st_nxt    = res_st_r;
          hash_clear    = 1'b1;
          cnt_nxt       = '0;
          flag_nxt      = 1'b0;
          state_nxt     = sith_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sith_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sith_pkg::S_CLEAR;
      slot_r      <= '0;
      cnt_r       <= '0;
      flag_r      <= 1'b0;
      pool_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      cnt_r       <= cnt_nxt;
      flag_r      <= flag_nxt;
      pool_r      <= pool_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r  <= probe_nxt;
    mod_r    <= mod_nxt;
    modcnt_r <= modcnt_nxt;
    i_r      <= i_nxt;
    cur_id_r <= cur_id_nxt;
    res_id_r <= res_id_nxt;
    res_st_r <= res_st_nxt;
    out_id_r <= out_id_nxt;
    out_st_r <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_st_r, out_id_r};

endmodule

// ===== test/sith_checker.sv =====
// ----------------------------------------------------------------------------
// sith_checker
// Watches both streams of the string intern table, predicts the result of
// every key and compares each delivered word field by field.
// ----------------------------------------------------------------------------
module sith_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [15:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  output int         fail_count,
  output int         pending
);

  localparam int          SLOTS    = sith_pkg::SLOT_COUNT_DEF;
  localparam int          KEY_MAX  = sith_pkg::MAX_KEY_LEN_DEF;
  localparam logic [63:0] FNV_MULT = 64'd1099511628211;

  logic [sith_pkg::ID_W-1:0] slot_ids [SLOTS];
  logic [7:0]      interned_bytes [sith_pkg::ID_LIMIT][KEY_MAX];
  int              interned_len [sith_pkg::ID_LIMIT];
  logic [7:0]      key_bytes [KEY_MAX];
  logic [63:0]     key_hash;
  int              key_len;
  logic            key_overflow;
  int              interned_count;
  logic [7:0]      result_q [$];

  initial begin
    for (int i = 0; i < SLOTS; i++) slot_ids[i] = '0;
    key_hash       = sith_pkg::FNV_BASIS;
    key_len        = 0;
    key_overflow   = 1'b0;
    interned_count = 0;
    fail_count     = 0;
    pending        = 0;
  end

  // Result word of the key held in key_bytes: {status, entry_id}.
  function automatic logic [7:0] lookup_key();
    int              slot;
    int              n;
    logic [sith_pkg::ID_W-1:0] id;
    logic            same;
    if (key_overflow) return {sith_pkg::ST_TOO_LONG, 6'd0};
    slot = int'(key_hash % SLOTS);
    for (n = 0; n < SLOTS; n++) begin
      id = slot_ids[slot];
      if (id == 0) break;
      if (interned_len[id] == key_len) begin
        same = 1'b1;
        for (int k = 0; k < key_len; k++)
          if (interned_bytes[id][k] != key_bytes[k]) same = 1'b0;
        if (same) return {sith_pkg::ST_HIT, id};
      end
      slot = (slot + 1) % SLOTS;
    end
    if (n == SLOTS ||
        (interned_count + 2) * sith_pkg::LOAD_DEN > SLOTS * sith_pkg::LOAD_NUM ||
        interned_count + 1 >= sith_pkg::ID_LIMIT)
      return {sith_pkg::ST_FULL, 6'd0};
    interned_count++;
    for (int k = 0; k < key_len; k++) interned_bytes[interned_count][k] = key_bytes[k];
    interned_len[interned_count] = key_len;
    slot_ids[slot] = interned_count[sith_pkg::ID_W-1:0];
    return {sith_pkg::ST_INSERTED, interned_count[sith_pkg::ID_W-1:0]};
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    logic [7:0] predicted;
    if (rst_n) begin
      // A result at this edge always belongs to an earlier key.
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time,
                   out_tdata);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (out_tdata[5:0] != want[5:0]) begin
            $display("%0t: entry_id mismatch, expected %0d, actual %0d", $time,
                     want[5:0], out_tdata[5:0]);
            fail_count++;
          end
          if (out_tdata[7:6] != want[7:6]) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     want[7:6], out_tdata[7:6]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tdata[8]) begin
          key_hash = (key_hash ^ {56'd0, in_tdata[7:0]}) * FNV_MULT;
          if (key_len < KEY_MAX) begin
            key_bytes[key_len] = in_tdata[7:0];
            key_len++;
          end else begin
            key_overflow = 1'b1;
          end
        end
        if (in_tlast) begin
          predicted    = lookup_key();
          result_q     = {result_q, predicted};
          key_hash     = sith_pkg::FNV_BASIS;
          key_len      = 0;
          key_overflow = 1'b0;
        end
      end
      pending = result_q.size();
    end
  end

endmodule

// ===== test/string_intern_hash_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// string_intern_hash_table_top_tb
// Streams directed and random keys into the intern table with random gaps
// and back-pressure, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module string_intern_hash_table_top_tb;
  localparam int WORD_TARGET = 1750;
  localparam int IDLE_LIMIT  = 50000;
  localparam int HIST_DEPTH  = 64;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  int          fail_count;
  int          pending;

  logic        quiet;
  logic        hold_req;
  logic        hold_done;
  logic        pause_done;
  int          words_sent;
  int          idle_cycles;
  logic [7:0]  key_bytes [36];
  int          key_len;
  logic [7:0]  hist_bytes [HIST_DEPTH][36];
  int          hist_len [HIST_DEPTH];
  int          hist_n;

  string_intern_hash_table_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  sith_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request, none near the end.
  initial begin
    out_tready <= 1'b0;
    hold_done  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic put_word(input logic [7:0] b, input logic present, input logic last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, present, b};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (present || last) words_sent++;
  endtask

  // Sends key_bytes[0 +: key_len]; the last byte may carry tlast itself.
  task automatic send_key(input logic last_on_byte, input logic noise);
    for (int i = 0; i < key_len; i++) begin
      if (noise && $urandom_range(0, 9) == 0)
        put_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      put_word(key_bytes[i], 1'b1, last_on_byte && i == key_len - 1);
    end
    if (!last_on_byte || key_len == 0) put_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    int pick;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    rst_n       <= 1'b0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    pause_done  = 1'b0;
    words_sent  = 0;
    idle_cycles = 0;
    hist_n      = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: the empty key twice, a one-byte key ending on its byte and
    // then on a separate terminator, the extreme byte values, a noisy key.
    key_len = 0;
    send_key(1'b0, 1'b0);
    send_key(1'b0, 1'b0);
    key_len = 1; key_bytes[0] = 8'h41;
    send_key(1'b1, 1'b0);
    send_key(1'b0, 1'b0);
    key_bytes[0] = 8'h00;
    send_key(1'b1, 1'b0);
    key_bytes[0] = 8'hff;
    send_key(1'b1, 1'b0);
    key_len = 3; key_bytes[0] = 8'h00; key_bytes[1] = 8'hff; key_bytes[2] = 8'h5a;
    put_word(8'h33, 1'b0, 1'b0);
    send_key(1'b1, 1'b0);
    send_key(1'b0, 1'b0);

    // Random keys: many repeats so that hits and long probe chains appear.
    while (words_sent < WORD_TARGET) begin
      if (words_sent > WORD_TARGET * 85 / 100) quiet = 1'b1;
      if (words_sent > 300 && !hold_req) hold_req = 1'b1;
      if (words_sent > 700 && !pause_done) begin
        // Pause until the table has answered every key.
        pause_done = 1'b1;
        in_tvalid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      if (hist_n > 0 && $urandom_range(0, 9) < 4) begin
        pick    = $urandom_range(0, hist_n - 1);
        key_len = hist_len[pick];
        for (int i = 0; i < key_len; i++) key_bytes[i] = hist_bytes[pick][i];
      end else begin
        if ($urandom_range(0, 99) < 6) key_len = $urandom_range(30, 36);
        else key_len = $urandom_range(0, 6);
        for (int i = 0; i < key_len; i++) key_bytes[i] = 8'($urandom_range(0, 255));
        if (hist_n < HIST_DEPTH && key_len <= 33) begin
          hist_len[hist_n] = key_len;
          for (int i = 0; i < key_len; i++) hist_bytes[hist_n][i] = key_bytes[i];
          hist_n++;
        end
      end
      send_key(1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
    end

    in_tvalid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
